### hw/rtl/lrud_pkg.sv
// Shared types and codes for the LRU cache directory.
package lrud_pkg;

  localparam int BLOCK_W = 48;
  localparam int IDX_W = 6;
  localparam int CNT_W = 7;
  localparam int CTR_W = 32;

  localparam logic [2:0] OP_LOOKUP = 3'd0;
  localparam logic [2:0] OP_QUIET  = 3'd1;
  localparam logic [2:0] OP_TOUCH  = 3'd2;
  localparam logic [2:0] OP_DETACH = 3'd3;
  localparam logic [2:0] OP_INSERT = 3'd4;
  localparam logic [2:0] OP_EVICT  = 3'd5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_FREE  = 2'd1;
  localparam logic [1:0] ST_UNUSABLE = 2'd2;
  localparam logic [1:0] ST_NO_VICT  = 2'd3;

  localparam logic [1:0] ES_FREE     = 2'd0;
  localparam logic [1:0] ES_USED     = 2'd1;
  localparam logic [1:0] ES_DETACHED = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_UPDATE,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic update;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } stat_t;

endpackage

### hw/rtl/lrud_if.sv
// Valid/ready channel interface carrying one payload.
interface lrud_if #(parameter type payload_t = logic) ();
  logic valid;
  logic ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/lrud_ctrl.sv
// Controller state machine of the LRU cache directory.
module lrud_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  lrud_pkg::stat_t stat,
  output lrud_pkg::cmd_t cmd
);
  lrud_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= lrud_pkg::S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      lrud_pkg::S_IDLE: if (in_valid && !stat.out_busy) state_next = lrud_pkg::S_SCAN;
      lrud_pkg::S_SCAN: state_next = lrud_pkg::S_UPDATE;
      lrud_pkg::S_UPDATE: state_next = lrud_pkg::S_DONE;
      lrud_pkg::S_DONE: if (!stat.out_busy) state_next = lrud_pkg::S_IDLE;
      default: state_next = lrud_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      lrud_pkg::S_IDLE: begin
        in_ready = !stat.out_busy;
        cmd.load = in_valid && !stat.out_busy;
      end
      lrud_pkg::S_SCAN: cmd.scan = 1'b1;
      lrud_pkg::S_UPDATE: cmd.update = 1'b1;
      lrud_pkg::S_DONE: cmd.emit = !stat.out_busy;
      default: ;
    endcase
  end
endmodule

### hw/rtl/lrud_datapath.sv
// Directory datapath: entry store, status, ranks, counters and result register.
module lrud_datapath #(
  parameter int CAPACITY = 64
) (
  input  logic clk,
  input  logic rst,
  input  lrud_pkg::cmd_t cmd,
  output lrud_pkg::stat_t stat,
  input  logic [2:0] in_opcode,
  input  logic [lrud_pkg::BLOCK_W-1:0] in_block,
  input  logic [lrud_pkg::IDX_W-1:0] in_index,
  input  logic in_reuse,
  input  logic [lrud_pkg::CNT_W-1:0] in_wm,
  output logic out_valid,
  input  logic out_ready,
  output logic [1:0] out_status,
  output logic out_hit,
  output logic [lrud_pkg::IDX_W-1:0] out_index,
  output logic [lrud_pkg::BLOCK_W-1:0] out_block,
  output logic [lrud_pkg::CNT_W-1:0] out_free,
  output logic [lrud_pkg::CNT_W-1:0] out_used,
  output logic [lrud_pkg::CTR_W-1:0] out_refs,
  output logic [lrud_pkg::CTR_W-1:0] out_hits,
  output logic [lrud_pkg::CTR_W-1:0] out_misses
);
  localparam int EW = $clog2(CAPACITY);
  localparam int RW = $clog2(CAPACITY);
  localparam int TW = $clog2(CAPACITY + 1);

  logic [lrud_pkg::BLOCK_W-1:0] blk [CAPACITY];
  logic [1:0] est [CAPACITY];
  logic [RW-1:0] rank [CAPACITY];
  logic [TW-1:0] free_total, used_total;
  logic [lrud_pkg::CTR_W-1:0] refs, hits, misses;

  logic [2:0] op;
  logic [lrud_pkg::BLOCK_W-1:0] key;
  logic [lrud_pkg::IDX_W-1:0] idx;
  logic reuse;
  logic [lrud_pkg::CNT_W-1:0] wm;

  logic [CAPACITY-1:0] match_vec, free_vec, lru_vec;
  logic [CAPACITY-1:0] match_r, free_r, lru_r;
  logic [EW-1:0] match_e, free_e, lru_e;
  logic match_any, free_any, lru_any;

  logic act;
  logic [EW-1:0] tgt;
  logic [1:0] res_status;
  logic res_hit;
  logic [RW-1:0] tgt_rank;
  logic rk_inc_lt, rk_dec_gt, rk_inc_all, do_count, do_hit;
  logic [1:0] tgt_st;
  logic idx_ok;
  logic ins_ok;

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      match_vec[i] = (est[i] == lrud_pkg::ES_USED) && (blk[i] == key);
      free_vec[i] = (est[i] == lrud_pkg::ES_FREE);
      lru_vec[i] = (est[i] == lrud_pkg::ES_USED) &&
                   (rank[i] == RW'(used_total - 1'b1));
    end
  end

  always_comb begin
    match_e = '0;
    match_any = 1'b0;
    lru_e = '0;
    lru_any = 1'b0;
    free_e = '0;
    free_any = 1'b0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (match_r[i]) begin
        match_e = EW'(i);
        match_any = 1'b1;
      end
      if (lru_r[i]) begin
        lru_e = EW'(i);
        lru_any = 1'b1;
      end
    end
    for (int i = 0; i < CAPACITY; i++) begin
      if (free_r[i]) begin
        free_e = EW'(i);
        free_any = 1'b1;
      end
    end
  end

  assign idx_ok = ({1'b0, idx} < (lrud_pkg::IDX_W + 1)'(CAPACITY));
  assign tgt_st = est[EW'(idx)];
  assign ins_ok = reuse ? (idx_ok && tgt_st == lrud_pkg::ES_DETACHED) : free_any;

  always_comb begin
    act = 1'b0;
    tgt = '0;
    res_status = lrud_pkg::ST_OK;
    res_hit = 1'b0;
    rk_inc_lt = 1'b0;
    rk_dec_gt = 1'b0;
    rk_inc_all = 1'b0;
    do_count = 1'b0;
    do_hit = match_any;
    case (op)
      lrud_pkg::OP_LOOKUP, lrud_pkg::OP_QUIET: begin
        do_count = (op == lrud_pkg::OP_LOOKUP);
        tgt = match_e;
        res_hit = match_any;
        act = match_any;
      end
      lrud_pkg::OP_TOUCH, lrud_pkg::OP_DETACH: begin
        if (idx_ok && tgt_st == lrud_pkg::ES_USED) begin
          tgt = EW'(idx);
          act = 1'b1;
          rk_inc_lt = (op == lrud_pkg::OP_TOUCH);
          rk_dec_gt = (op == lrud_pkg::OP_DETACH);
        end else begin
          res_status = lrud_pkg::ST_UNUSABLE;
        end
      end
      lrud_pkg::OP_INSERT: begin
        if (ins_ok) begin
          tgt = reuse ? EW'(idx) : free_e;
          act = 1'b1;
          rk_inc_all = 1'b1;
        end else begin
          res_status = reuse ? lrud_pkg::ST_UNUSABLE : lrud_pkg::ST_NO_FREE;
        end
      end
      lrud_pkg::OP_EVICT: begin
        if ({1'b0, free_total} < (TW + 1)'({1'b0, wm}) + 1'b1) begin
          if (lru_any && used_total != '0) begin
            tgt = lru_e;
            act = 1'b1;
            res_hit = 1'b1;
            rk_dec_gt = 1'b1;
          end else begin
            res_status = lrud_pkg::ST_NO_VICT;
          end
        end
      end
      default: ;
    endcase
  end

  assign tgt_rank = rank[tgt];
  assign stat.out_busy = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op <= in_opcode;
      key <= in_block;
      idx <= in_index;
      reuse <= in_reuse;
      wm <= in_wm;
    end
    if (cmd.scan) begin
      match_r <= match_vec;
      free_r <= free_vec;
      lru_r <= lru_vec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CAPACITY; i++) begin
        est[i] <= lrud_pkg::ES_FREE;
        rank[i] <= '0;
      end
      free_total <= TW'(CAPACITY);
      used_total <= '0;
      refs <= '0;
      hits <= '0;
      misses <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cmd.emit) out_valid <= 1'b1;
      if (cmd.update) begin
        if (do_count) begin
          refs <= refs + 1'b1;
          if (do_hit) hits <= hits + 1'b1;
          else misses <= misses + 1'b1;
        end
        if (act) begin
          for (int i = 0; i < CAPACITY; i++) begin
            if (est[i] == lrud_pkg::ES_USED && EW'(i) != tgt) begin
              if (rk_inc_all || (rk_inc_lt && rank[i] < tgt_rank))
                rank[i] <= rank[i] + 1'b1;
              else if (rk_dec_gt && rank[i] > tgt_rank)
                rank[i] <= rank[i] - 1'b1;
            end
          end
          if (rk_inc_lt || rk_dec_gt || rk_inc_all) rank[tgt] <= '0;
          if (rk_dec_gt) begin
            est[tgt] <= lrud_pkg::ES_DETACHED;
            free_total <= free_total + 1'b1;
            used_total <= used_total - 1'b1;
          end
          if (rk_inc_all) begin
            est[tgt] <= lrud_pkg::ES_USED;
            free_total <= free_total - 1'b1;
            used_total <= used_total + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      if (act && rk_inc_all) blk[tgt] <= key;
      out_status <= res_status;
      out_hit <= res_hit;
      out_index <= act ? lrud_pkg::IDX_W'(tgt) : '0;
      out_block <= act ? (rk_inc_all ? key : blk[tgt]) : '0;
    end
    if (cmd.emit) begin
      out_free <= lrud_pkg::CNT_W'(free_total);
      out_used <= lrud_pkg::CNT_W'(used_total);
      out_refs <= refs;
      out_hits <= hits;
      out_misses <= misses;
    end
  end
endmodule

### hw/rtl/lru_cache_directory_core.sv
// Top level of the LRU cache directory.
// Usage:
//   req carries opcode, block_number, entry_index, reuse_entry, watermark.
//   rsp carries status, hit, entry_index_out, block_out, the free and used
//   counts and the three lookup counters after the operation.
//   One rsp transfer follows each req transfer.
// Timing:
//   A request is taken in idle, its tags are matched against all entries
//   in the next cycle (registered match vectors), and the rank, status and
//   counter update lands in the cycle after; the response is then registered
//   in the done state. One request is in flight at a time.
// Reset:
//   All entries free, ranks zero, counters zero, rsp empty.
// Stall:
//   While rsp is held, the result waits in its register and no new
//   request is taken.
module lru_cache_directory_core #(
  parameter int CAPACITY = 64
) (
  input logic clk,
  input logic rst,
  lrud_if.sink req,
  lrud_if.source rsp
);
  lrud_pkg::cmd_t cmd;
  lrud_pkg::stat_t stat;

  lrud_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(req.valid), .in_ready(req.ready),
    .stat(stat), .cmd(cmd)
  );

  lrud_datapath #(.CAPACITY(CAPACITY)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .in_opcode(req.data.opcode),
    .in_block(req.data.block_number),
    .in_index(req.data.entry_index),
    .in_reuse(req.data.reuse_entry),
    .in_wm(req.data.watermark),
    .out_valid(rsp.valid), .out_ready(rsp.ready),
    .out_status(rsp.data.status),
    .out_hit(rsp.data.hit),
    .out_index(rsp.data.entry_index_out),
    .out_block(rsp.data.block_out),
    .out_free(rsp.data.free_count),
    .out_used(rsp.data.used_count),
    .out_refs(rsp.data.ref_count),
    .out_hits(rsp.data.hit_count),
    .out_misses(rsp.data.miss_count)
  );
endmodule

### hw/rtl/lrud_checker.sv
// Port-level assertions for the LRU cache directory, bound to the top level.
module lrud_checker (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input logic rsp_valid,
  input logic rsp_ready,
  input logic [1:0] status,
  input logic hit
);
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |-> !req_ready) else $error("req taken while rsp pending");
  a_gap: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !rsp_valid) else $error("rsp too early");
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> rsp_valid) else $error("rsp dropped");
  a_err_nohit: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && status != 2'd0) |-> !hit) else $error("hit on error");
endmodule

bind lru_cache_directory_core lrud_checker u_chk (
  .clk(clk), .rst(rst),
  .req_valid(req.valid), .req_ready(req.ready),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
  .status(rsp.data.status), .hit(rsp.data.hit)
);

### bench/lrud_tb_pkg.sv
// Request and response payload types for the LRU cache directory bench.
package lrud_tb_pkg;

  typedef struct packed {
    logic [2:0] opcode;
    logic [lrud_pkg::BLOCK_W-1:0] block_number;
    logic [lrud_pkg::IDX_W-1:0] entry_index;
    logic reuse_entry;
    logic [lrud_pkg::CNT_W-1:0] watermark;
  } dir_req_t;

  typedef struct packed {
    logic [1:0] status;
    logic hit;
    logic [lrud_pkg::IDX_W-1:0] entry_index_out;
    logic [lrud_pkg::BLOCK_W-1:0] block_out;
    logic [lrud_pkg::CNT_W-1:0] free_count;
    logic [lrud_pkg::CNT_W-1:0] used_count;
    logic [lrud_pkg::CTR_W-1:0] ref_count;
    logic [lrud_pkg::CTR_W-1:0] hit_count;
    logic [lrud_pkg::CTR_W-1:0] miss_count;
  } dir_rsp_t;

endpackage

### bench/tb_top.sv
// Self-checking bench for the LRU cache directory core.
module tb_top;

  localparam int ENTRIES = 64;

  logic clk;
  logic rst;

  lrud_if #(.payload_t(lrud_tb_pkg::dir_req_t)) req_ch ();
  lrud_if #(.payload_t(lrud_tb_pkg::dir_rsp_t)) rsp_ch ();

  lru_cache_directory_core #(.CAPACITY(ENTRIES)) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch.sink),
    .rsp(rsp_ch.source)
  );

  lrud_tb_pkg::dir_req_t pending_ops[$];
  lrud_tb_pkg::dir_rsp_t due_rsps[$];
  logic [lrud_pkg::BLOCK_W-1:0] blk_pool[16];
  int mismatches = 0;
  int cycle = 0;
  bit stim_done = 0;

  logic [lrud_pkg::BLOCK_W-1:0] m_block[ENTRIES];
  logic [1:0] m_state[ENTRIES];
  int m_rank[ENTRIES];
  int m_free, m_used;
  logic [lrud_pkg::CTR_W-1:0] m_refs, m_hits, m_misses;

  function automatic void rank_bump_all();
    for (int i = 0; i < ENTRIES; i++) if (m_state[i] == lrud_pkg::ES_USED) m_rank[i]++;
  endfunction

  function automatic void unlink(int e);
    for (int i = 0; i < ENTRIES; i++)
      if (m_state[i] == lrud_pkg::ES_USED && m_rank[i] > m_rank[e]) m_rank[i]--;
    m_state[e] = lrud_pkg::ES_DETACHED;
    m_rank[e] = 0;
    m_free++;
    m_used--;
  endfunction

  function automatic lrud_tb_pkg::dir_rsp_t directory_step(lrud_tb_pkg::dir_req_t r);
    lrud_tb_pkg::dir_rsp_t o;
    int rep;
    int e;
    int rk;
    rep = -1;
    o = '0;
    o.status = lrud_pkg::ST_OK;
    case (r.opcode)
      lrud_pkg::OP_LOOKUP, lrud_pkg::OP_QUIET: begin
        for (int i = 0; i < ENTRIES; i++)
          if (rep < 0 && m_state[i] == lrud_pkg::ES_USED &&
              m_block[i] == r.block_number) rep = i;
        o.hit = rep >= 0;
        if (r.opcode == lrud_pkg::OP_LOOKUP) begin
          m_refs++;
          if (rep >= 0) m_hits++;
          else m_misses++;
        end
      end
      lrud_pkg::OP_TOUCH, lrud_pkg::OP_DETACH: begin
        if (m_state[r.entry_index] == lrud_pkg::ES_USED) begin
          rep = int'(r.entry_index);
          if (r.opcode == lrud_pkg::OP_TOUCH) begin
            rk = m_rank[rep];
            for (int i = 0; i < ENTRIES; i++)
              if (m_state[i] == lrud_pkg::ES_USED && m_rank[i] < rk) m_rank[i]++;
            m_rank[rep] = 0;
          end else begin
            unlink(rep);
          end
        end else begin
          o.status = lrud_pkg::ST_UNUSABLE;
        end
      end
      lrud_pkg::OP_INSERT: begin
        e = -1;
        if (r.reuse_entry) begin
          if (m_state[r.entry_index] == lrud_pkg::ES_DETACHED) e = int'(r.entry_index);
          else o.status = lrud_pkg::ST_UNUSABLE;
        end else begin
          for (int i = ENTRIES - 1; i >= 0; i--)
            if (e < 0 && m_state[i] == lrud_pkg::ES_FREE) e = i;
          if (e < 0) o.status = lrud_pkg::ST_NO_FREE;
        end
        if (e >= 0) begin
          rank_bump_all();
          m_block[e] = r.block_number;
          m_state[e] = lrud_pkg::ES_USED;
          m_rank[e] = 0;
          m_free--;
          m_used++;
          rep = e;
        end
      end
      lrud_pkg::OP_EVICT: begin
        if (m_free < int'(r.watermark) + 1) begin
          for (int i = 0; i < ENTRIES; i++)
            if (rep < 0 && m_state[i] == lrud_pkg::ES_USED && m_rank[i] == m_used - 1)
              rep = i;
          if (rep >= 0) begin
            unlink(rep);
            o.hit = 1'b1;
          end else begin
            o.status = lrud_pkg::ST_NO_VICT;
          end
        end
      end
      default: ;
    endcase
    if (rep >= 0) begin
      o.entry_index_out = lrud_pkg::IDX_W'(rep);
      o.block_out = m_block[rep];
    end
    o.free_count = lrud_pkg::CNT_W'(m_free);
    o.used_count = lrud_pkg::CNT_W'(m_used);
    o.ref_count = m_refs;
    o.hit_count = m_hits;
    o.miss_count = m_misses;
    return o;
  endfunction

  function automatic lrud_tb_pkg::dir_req_t mk(logic [2:0] op,
                                               logic [lrud_pkg::BLOCK_W-1:0] b,
                                               logic [lrud_pkg::IDX_W-1:0] ix, logic ru,
                                               logic [lrud_pkg::CNT_W-1:0] wm);
    lrud_tb_pkg::dir_req_t r;
    r.opcode = op;
    r.block_number = b;
    r.entry_index = ix;
    r.reuse_entry = ru;
    r.watermark = wm;
    return r;
  endfunction

  function automatic logic [lrud_pkg::BLOCK_W-1:0] rand_blk();
    return {16'($urandom_range(16'hffff, 0)), $urandom()};
  endfunction

  function automatic bit idle_now();
    return !(cycle > 1200 && cycle < 2400) && ($urandom_range(99, 0) < 38);
  endfunction

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst = 1;
    repeat (5) @(posedge clk);
    rst <= 0;
  end

  always @(posedge clk) cycle <= cycle + 1;

  initial begin
    logic [2:0] op;
    int pick;
    logic [lrud_pkg::CNT_W-1:0] wm;
    for (int i = 0; i < 16; i++) blk_pool[i] = rand_blk();
    blk_pool[0] = '0;
    blk_pool[1] = '1;
    pending_ops.push_back(mk(lrud_pkg::OP_LOOKUP, '1, '0, '0, '0));
    pending_ops.push_back(mk(lrud_pkg::OP_EVICT, '0, '0, '0, 7'd64));
    pending_ops.push_back(mk(lrud_pkg::OP_EVICT, '0, '0, '0, 7'd0));
    pending_ops.push_back(mk(lrud_pkg::OP_TOUCH, '0, 6'd63, '0, '0));
    pending_ops.push_back(mk(lrud_pkg::OP_DETACH, '0, 6'd0, '0, '0));
    pending_ops.push_back(mk(lrud_pkg::OP_INSERT, '0, 6'd5, 1'b1, '0));
    pending_ops.push_back(mk(lrud_pkg::OP_INSERT, '0, '0, '0, '0));
    pending_ops.push_back(mk(lrud_pkg::OP_INSERT, '1, '0, '0, '0));
    pending_ops.push_back(mk(lrud_pkg::OP_INSERT, '1, 6'h3f, '0, 7'h7f));
    pending_ops.push_back(mk(lrud_pkg::OP_LOOKUP, '1, '0, '0, '0));
    pending_ops.push_back(mk(lrud_pkg::OP_QUIET, '0, '0, '0, '0));
    pending_ops.push_back(mk(lrud_pkg::OP_TOUCH, '0, 6'd63, '0, '0));
    pending_ops.push_back(mk(lrud_pkg::OP_DETACH, '0, 6'd62, '0, '0));
    pending_ops.push_back(mk(lrud_pkg::OP_LOOKUP, '1, '0, '0, '0));
    pending_ops.push_back(mk(lrud_pkg::OP_INSERT, 48'h123, 6'd62, 1'b1, '0));
    pending_ops.push_back(mk(lrud_pkg::OP_EVICT, '0, '0, '0, 7'd64));
    pending_ops.push_back(mk(3'd6, '1, '1, 1'b1, '1));
    pending_ops.push_back(mk(3'd7, '0, '0, '0, '0));
    for (int i = 0; i < 64; i++)
      pending_ops.push_back(mk(lrud_pkg::OP_INSERT, blk_pool[4'(i)], '0, '0, '0));
    pending_ops.push_back(mk(lrud_pkg::OP_INSERT, 48'h5, '0, '0, '0));
    pending_ops.push_back(mk(lrud_pkg::OP_EVICT, '0, '0, '0, 7'd0));
    pending_ops.push_back(mk(lrud_pkg::OP_INSERT, 48'h5, '0, '0, '0));
    for (int n = 0; n < 615; n++) begin
      pick = $urandom_range(99, 0);
      if (pick < 28) op = $urandom_range(1, 0) ? lrud_pkg::OP_LOOKUP : lrud_pkg::OP_QUIET;
      else if (pick < 40) op = lrud_pkg::OP_TOUCH;
      else if (pick < 50) op = lrud_pkg::OP_DETACH;
      else if (pick < 78) op = lrud_pkg::OP_INSERT;
      else if (pick < 97) op = lrud_pkg::OP_EVICT;
      else op = 3'($urandom_range(7, 0));
      if ($urandom_range(3, 0) == 0) wm = 7'($urandom_range(127, 0));
      else wm = 7'($urandom_range(40, 0));
      pending_ops.push_back(mk(op,
        ($urandom_range(4, 0) != 0) ? blk_pool[4'($urandom_range(15, 0))] : rand_blk(),
        6'($urandom_range(63, 0)), 1'($urandom_range(1, 0)), wm));
    end
    stim_done = 1;
  end

  always @(posedge clk) begin
    lrud_tb_pkg::dir_req_t nxt;
    logic v;
    if (rst) begin
      req_ch.valid <= 1'b0;
      req_ch.data <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        m_block[i] = '0;
        m_state[i] = lrud_pkg::ES_FREE;
        m_rank[i] = 0;
      end
      m_free = ENTRIES;
      m_used = 0;
      m_refs = '0;
      m_hits = '0;
      m_misses = '0;
    end else begin
      v = req_ch.valid;
      if (req_ch.valid && req_ch.ready) begin
        due_rsps.push_back(directory_step(req_ch.data));
        v = 1'b0;
      end
      if (!v && pending_ops.size() > 0 && !idle_now()) begin
        nxt = pending_ops.pop_front();
        req_ch.data <= nxt;
        v = 1'b1;
      end
      req_ch.valid <= v;
    end
  end

  always @(posedge clk) begin
    lrud_tb_pkg::dir_rsp_t want;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (due_rsps.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected transfer %p", rsp_ch.data);
        end else begin
          want = due_rsps.pop_front();
          if (rsp_ch.data !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp %p got %p", want, rsp_ch.data);
          end
        end
      end
      rsp_ch.ready <= !idle_now();
    end
  end

  initial begin
    wait (stim_done);
    @(posedge clk);
    while (pending_ops.size() > 0 || req_ch.valid || due_rsps.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && due_rsps.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_top failed");
    $finish;
  end

endmodule
